FILE: rtl/core/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box and round helper functions.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int unsigned HalfW   = 64;
	localparam int unsigned BlockW  = 128;
	localparam int unsigned Rounds  = 10;
	localparam int unsigned IdxW    = 1;
	localparam logic [IdxW-1:0] RegKeyHigh = 1'b0;
	localparam logic [IdxW-1:0] RegKeyLow  = 1'b1;

	typedef logic [BlockW-1:0] block_t;

	function automatic logic [7:0] sbox(input logic [7:0] v);
		logic [7:0] r;
		case (v)
			8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
			8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
			8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
			8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
			8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
			8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
			8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
			8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
			8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
			8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
			8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
			8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
			8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
			8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
			8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
			8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
			8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
			8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
			8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
			8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
			8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
			8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
			8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
			8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
			8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
			8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
			8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
			8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
			8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
			8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
			8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
			8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
			8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
			8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
			8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
			8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
			8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
			8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
			8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
			8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
			8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
			8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
			8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
			8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
			8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
			8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
			8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
			8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
			8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
			8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
			8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
			8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
			8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
			default: r=8'h00;
		endcase
		return r;
	endfunction

	// GF(2^8) doubling, reduction polynomial 0x1B
	function automatic logic [7:0] gf_dbl(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
		return b[BlockW-1-8*i -: 8];
	endfunction

	// SubBytes + ShiftRows; byte (row r, col c) is index 4c+r
	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BlockW-1-8*(4*c+r) -: 8] = sbox(get_byte(s, 4*((c+r)%4)+r));
			end
		end
		return t;
	endfunction

	function automatic block_t mix_cols(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);   a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
			d0 = gf_dbl(a0); d1 = gf_dbl(a1); d2 = gf_dbl(a2); d3 = gf_dbl(a3);
			t[BlockW-1-8*(4*c)   -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
			t[BlockW-1-8*(4*c+1) -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
			t[BlockW-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
			t[BlockW-1-8*(4*c+3) -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
		end
		return t;
	endfunction

	// next round key from the previous one
	function automatic block_t next_key(input block_t k, input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

FILE: rtl/core/aes_if.sv
// ----------------------------------------------------------------------------
// AES stream interfaces
// Valid/ready block channel and configuration write channel.
// ----------------------------------------------------------------------------
interface aes_blk_if;
	logic valid;
	logic ready;
	logic [aes_pkg::HalfW-1:0] high;
	logic [aes_pkg::HalfW-1:0] low;
	modport source (output valid, output high, output low, input ready);
	modport sink (input valid, input high, input low, output ready);
endinterface

interface aes_cfg_if;
	logic valid;
	logic ready;
	logic [aes_pkg::IdxW-1:0] index;
	logic [aes_pkg::HalfW-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/aes128_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// AES-128 block encrypt unit
// ECB encryption pipeline, one round per stage.
// ----------------------------------------------------------------------------
// The input transfer loads the initial key-add stage, and each of the ten
// round stages registers one round while computing its round key alongside
// the data; the result is taken from the last round stage. A new block is
// taken every cycle while the output side takes results; the whole pipeline
// holds when the last stage waits. Each block carries the key held when it
// was accepted. Key writes apply to blocks accepted afterwards; index values
// beyond key_low are ignored.
module aes128_block_encrypt_unit (
	input  logic      clk,
	input  logic      arst_n,
	aes_cfg_if.sink   cfg,
	aes_blk_if.sink   plain,
	aes_blk_if.source cipher
);
	localparam int unsigned N = aes_pkg::Rounds;
	localparam logic [7:0] RCON [N] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

	logic [aes_pkg::HalfW-1:0] key_high_q, key_low_q;
	logic                      en;
	logic            v   [N+1];
	aes_pkg::block_t st  [N+1];
	aes_pkg::block_t ky  [N+1];

	assign cfg.ready = 1'b1;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				aes_pkg::RegKeyHigh: key_high_q <= cfg.data;
				aes_pkg::RegKeyLow:  key_low_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// pipeline advances unless the output holds a result not taken
	assign en = !v[N] || cipher.ready;
	assign plain.ready = en;

	// stage zero: initial AddRoundKey
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= plain.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st[0] <= {plain.high, plain.low} ^ {key_high_q, key_low_q};
			ky[0] <= {key_high_q, key_low_q};
		end
	end

	for (genvar g = 0; g < N; g++) begin : g_rnd
		aes_round #(.RCON(RCON[g]), .LAST(g == N-1)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (v[g]),
			.state_in (st[g]),
			.key_in   (ky[g]),
			.valid_s1 (v[g+1]),
			.state_s1 (st[g+1]),
			.key_s1   (ky[g+1])
		);
	end

	assign cipher.valid = v[N];
	assign cipher.high  = st[N][aes_pkg::BlockW-1:aes_pkg::HalfW];
	assign cipher.low   = st[N][aes_pkg::HalfW-1:0];

	// a stalled result holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cipher.valid && !cipher.ready |=> cipher.valid && $stable(cipher.high)
			&& $stable(cipher.low))
		else $error("result changed while stalled");
	// input is refused only when output stalls
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!plain.ready |-> cipher.valid && !cipher.ready)
		else $error("input refused without output stall");
	// an accepted block moves to stage zero
	a_s0: assert property (@(posedge clk) disable iff (!arst_n)
		plain.valid && plain.ready |=> v[0])
		else $error("accepted block lost");
endmodule

FILE: rtl/core/aes_round.sv
// ----------------------------------------------------------------------------
// AES round stage
// One cipher round and one key-schedule step, registered, with stall.
// ----------------------------------------------------------------------------
module aes_round #(
	parameter logic [7:0] RCON = 8'h01,
	parameter bit         LAST = 1'b0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  aes_pkg::block_t      state_in,
	input  aes_pkg::block_t      key_in,
	output logic                 valid_s1,
	output aes_pkg::block_t      state_s1,
	output aes_pkg::block_t      key_s1
);
	aes_pkg::block_t rk, ss, mc;

	// round key for this round, then the round datapath
	always_comb begin
		rk = aes_pkg::next_key(key_in, RCON);
		ss = aes_pkg::sub_shift(state_in);
		mc = LAST ? ss : aes_pkg::mix_cols(ss);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s1 <= mc ^ rk;
			key_s1   <= rk;
		end
	end
endmodule
